// ===== rtl/core/tlik_pkg.sv =====
// Shared types, widths and constants of the two-link planar inverse kinematics core.
// Every module of the core imports this package; it depends on nothing else.
`timescale 1ns / 1ps

package tlik_pkg;

    localparam int COORD_W      = 16;
    localparam int LEN_W        = 15;
    localparam int SQ_W         = 2 * COORD_W;
    localparam int LSQ_W        = 2 * LEN_W;
    localparam int PE_W         = 2 * LSQ_W;
    localparam int PS_W         = SQ_W + LSQ_W;
    localparam int NUM_W        = SQ_W + 1;
    localparam int AN_W         = SQ_W;
    localparam int RAD_W        = 2 * AN_W;
    localparam int ISQ_STEPS    = RAD_W / 2;
    localparam int ROOT_W       = ISQ_STEPS;
    localparam int NORM_TOP     = 30;
    localparam int MAG_W        = NORM_TOP + 3;
    localparam int CW           = MAG_W + 1;
    localparam int ANG_W        = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int NORM_STAGES  = 5;
    localparam int CORDIC_LAT   = CORDIC_STEPS + NORM_STAGES + 3;
    localparam int FRONT_LAT    = 5;

    localparam int S_DATA_W     = 48;
    localparam int M_DATA_W     = 48;
    localparam int SH_W         = 16;
    localparam int EL_W         = 14;
    localparam int CFG_IDX_W    = 1;

    localparam logic [LEN_W-1:0] LINK_RESET = 15'd1600;

    localparam logic signed [ANG_W-1:0] DEG90      = 32'sd94371840;
    localparam logic signed [ANG_W-1:0] ROUND_HALF = 32'sd8192;
    localparam int                      RND_SHIFT  = 14;
    localparam logic signed [ANG_W-1:0] SH_MIN     = -32'sd11520;
    localparam logic signed [ANG_W-1:0] SH_MAX     = 32'sd23040;
    localparam logic signed [ANG_W-1:0] EL_MAX     = 32'sd11520;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_LINK  = 1'b0,
        CFG_SECOND_LINK = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic                      bad;
        logic                      fz_e;
        logic                      fz_s;
        logic                      d2zero;
    } tail_t;

    typedef struct packed {
        logic signed [NUM_W-1:0]   num_e;
        logic signed [NUM_W-1:0]   num_s;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        tail_t                     tail;
    } mid_t;

    typedef struct packed {
        logic [RAD_W-1:0] rad_e;
        logic [RAD_W-1:0] rad_s;
        mid_t             mid;
    } front_t;

    // Arctangent of 2^-i in degrees with 20 fractional bits.
    function automatic logic signed [ANG_W-1:0] atan_deg(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 32'sd47185920;
            1:  v = 32'sd27855475;
            2:  v = 32'sd14718068;
            3:  v = 32'sd7471121;
            4:  v = 32'sd3750058;
            5:  v = 32'sd1876857;
            6:  v = 32'sd938658;
            7:  v = 32'sd469357;
            8:  v = 32'sd234682;
            9:  v = 32'sd117342;
            10: v = 32'sd58671;
            11: v = 32'sd29335;
            12: v = 32'sd14668;
            13: v = 32'sd7334;
            14: v = 32'sd3667;
            15: v = 32'sd1833;
            16: v = 32'sd917;
            17: v = 32'sd458;
            18: v = 32'sd229;
            19: v = 32'sd115;
            20: v = 32'sd57;
            21: v = 32'sd29;
            22: v = 32'sd14;
            23: v = 32'sd7;
            24: v = 32'sd4;
            25: v = 32'sd2;
            26: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/tlik_front.sv =====
// Front end of the inverse kinematics core: squares, products and the acos radicands.
// Five register stages; depends on tlik_pkg.
`timescale 1ns / 1ps

module tlik_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [tlik_pkg::COORD_W-1:0] x_in,
    input  logic signed [tlik_pkg::COORD_W-1:0] y_in,
    input  logic signed [tlik_pkg::COORD_W-1:0] z_in,
    input  logic [tlik_pkg::LEN_W-1:0]        l1_in,
    input  logic [tlik_pkg::LEN_W-1:0]        l2_in,
    output logic                              out_valid,
    output tlik_pkg::front_t                  out_data
);
    import tlik_pkg::*;

    logic [FRONT_LAT-1:0] valid_reg;

    logic signed [COORD_W-1:0] x1_reg, y1_reg, z1_reg;
    logic [SQ_W-1:0]           xx1_reg, yy1_reg;
    logic [LSQ_W-1:0]          l1s1_reg, l2s1_reg;
    logic signed [SQ_W-1:0]    xx_s, yy_s;
    logic [LSQ_W-1:0]          l1s, l2s;

    logic [SQ_W-1:0]  d2_next, d2_2_reg;
    logic [LSQ_W-1:0] l1s2_reg;
    logic [PE_W-1:0]  pe2_reg;
    mid_t             mid2_next, mid2_reg;

    logic signed [NUM_W-1:0] neg_e, neg_s;
    logic [AN_W-1:0]         an_e3_reg, an_s3_reg;
    logic [PS_W-1:0]         ps3_reg;
    logic [RAD_W-1:0]        den_e3_reg;
    mid_t                    mid3_next, mid3_reg;

    logic [RAD_W-1:0] nsq_e4_reg, nsq_s4_reg, den_e4_reg, den_s4_reg;
    mid_t             mid4_next, mid4_reg;

    logic [RAD_W:0]   diff_e, diff_s;
    logic             bad_e, bad_s;
    front_t           out_next, out_reg;

    assign xx_s = x_in * x_in;
    assign yy_s = y_in * y_in;
    assign l1s  = l1_in * l1_in;
    assign l2s  = l2_in * l2_in;

    always_comb begin
        d2_next   = xx1_reg + yy1_reg;
        mid2_next.num_e = $signed({3'b000, l1s1_reg}) + $signed({3'b000, l2s1_reg})
                        - $signed({1'b0, d2_next});
        mid2_next.num_s = $signed({1'b0, d2_next}) + $signed({3'b000, l1s1_reg})
                        - $signed({3'b000, l2s1_reg});
        mid2_next.x           = x1_reg;
        mid2_next.y           = y1_reg;
        mid2_next.tail.z      = z1_reg;
        mid2_next.tail.bad    = 1'b0;
        mid2_next.tail.fz_e   = 1'b0;
        mid2_next.tail.fz_s   = 1'b0;
        mid2_next.tail.d2zero = (d2_next == '0);
    end

    assign neg_e = -mid2_reg.num_e;
    assign neg_s = -mid2_reg.num_s;

    always_comb begin
        mid3_next           = mid2_reg;
        mid3_next.tail.fz_e = (pe2_reg == '0);
    end

    always_comb begin
        mid4_next           = mid3_reg;
        mid4_next.tail.fz_s = (ps3_reg == '0);
    end

    always_comb begin
        diff_e = {1'b0, den_e4_reg} - {1'b0, nsq_e4_reg};
        diff_s = {1'b0, den_s4_reg} - {1'b0, nsq_s4_reg};
        bad_e  = mid4_reg.tail.fz_e | diff_e[RAD_W];
        bad_s  = mid4_reg.tail.fz_s | diff_s[RAD_W];
        out_next.rad_e        = bad_e ? '0 : diff_e[RAD_W-1:0];
        out_next.rad_s        = bad_s ? '0 : diff_s[RAD_W-1:0];
        out_next.mid          = mid4_reg;
        out_next.mid.tail.bad = bad_e | bad_s | mid4_reg.tail.d2zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg     <= x_in;
            y1_reg     <= y_in;
            z1_reg     <= z_in;
            xx1_reg    <= $unsigned(xx_s);
            yy1_reg    <= $unsigned(yy_s);
            l1s1_reg   <= l1s;
            l2s1_reg   <= l2s;

            d2_2_reg   <= d2_next;
            l1s2_reg   <= l1s1_reg;
            pe2_reg    <= l1s1_reg * l2s1_reg;
            mid2_reg   <= mid2_next;

            an_e3_reg  <= mid2_reg.num_e[NUM_W-1] ? neg_e[AN_W-1:0] : mid2_reg.num_e[AN_W-1:0];
            an_s3_reg  <= mid2_reg.num_s[NUM_W-1] ? neg_s[AN_W-1:0] : mid2_reg.num_s[AN_W-1:0];
            ps3_reg    <= d2_2_reg * l1s2_reg;
            den_e3_reg <= {2'b00, pe2_reg, 2'b00};
            mid3_reg   <= mid3_next;

            nsq_e4_reg <= an_e3_reg * an_e3_reg;
            nsq_s4_reg <= an_s3_reg * an_s3_reg;
            den_e4_reg <= den_e3_reg;
            den_s4_reg <= {ps3_reg, 2'b00};
            mid4_reg   <= mid4_next;

            out_reg    <= out_next;
        end
    end

    assign out_valid = valid_reg[FRONT_LAT-1];
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/tlik_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on tlik_pkg for the radicand and root widths.
`timescale 1ns / 1ps

module tlik_isqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [tlik_pkg::RAD_W-1:0]     rad_in,
    output logic                           out_valid,
    output logic [tlik_pkg::ROOT_W-1:0]    root_out
);
    import tlik_pkg::*;

    logic [ISQ_STEPS-1:0] valid_reg;
    logic [RAD_W-1:0]     v_reg [ISQ_STEPS];
    logic [RAD_W-1:0]     r_reg [ISQ_STEPS];
    logic [RAD_W-1:0]     v_next [ISQ_STEPS];
    logic [RAD_W-1:0]     r_next [ISQ_STEPS];

    always_comb begin
        logic [RAD_W-1:0] v_in, r_in, bitv, trial;
        for (int k = 0; k < ISQ_STEPS; k++) begin
            v_in  = (k == 0) ? rad_in : v_reg[(k == 0) ? 0 : k - 1];
            r_in  = (k == 0) ? '0 : r_reg[(k == 0) ? 0 : k - 1];
            bitv  = RAD_W'(1) << (RAD_W - 2 - 2 * k);
            trial = r_in + bitv;
            if (v_in >= trial) begin
                v_next[k] = v_in - trial;
                r_next[k] = (r_in >> 1) + bitv;
            end else begin
                v_next[k] = v_in;
                r_next[k] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[ISQ_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ISQ_STEPS; k++) begin
                v_reg[k] <= v_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign out_valid = valid_reg[ISQ_STEPS-1];
    assign root_out  = r_reg[ISQ_STEPS-1][ROOT_W-1:0];

endmodule

// ===== rtl/core/tlik_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees with 20 fractional bits.
// Normalizes the operands over six stages, then one rotation per stage; uses tlik_pkg.
`timescale 1ns / 1ps

module tlik_cordic (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [tlik_pkg::CW-1:0]    y_in,
    input  logic signed [tlik_pkg::CW-1:0]    x_in,
    output logic                              out_valid,
    output logic signed [tlik_pkg::ANG_W-1:0] angle_out
);
    import tlik_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic [MAG_W-1:0] m;
        logic             xneg;
        logic             yneg;
        logic             zero;
    } norm_t;

    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } rot_t;

    logic [CORDIC_LAT-1:0] valid_reg;
    norm_t                 n0_reg, n0_next;
    norm_t                 norm_reg [NORM_STAGES+1];
    norm_t                 norm_next [NORM_STAGES+1];
    rot_t                  pre_reg, pre_next;
    rot_t                  rot_reg [CORDIC_STEPS];
    rot_t                  rot_next [CORDIC_STEPS];
    logic signed [CW-1:0]  nx, ny;

    assign nx = -x_in;
    assign ny = -y_in;

    always_comb begin
        n0_next.ax   = x_in[CW-1] ? nx[MAG_W-1:0] : x_in[MAG_W-1:0];
        n0_next.ay   = y_in[CW-1] ? ny[MAG_W-1:0] : y_in[MAG_W-1:0];
        n0_next.m    = (n0_next.ax > n0_next.ay) ? n0_next.ax : n0_next.ay;
        n0_next.xneg = x_in[CW-1];
        n0_next.yneg = y_in[CW-1];
        n0_next.zero = (n0_next.m == '0);
    end

    always_comb begin
        norm_t src;
        int    sh;
        for (int j = 0; j <= NORM_STAGES; j++) begin
            src = (j == 0) ? n0_reg : norm_reg[(j == 0) ? 0 : j - 1];
            norm_next[j] = src;
            if (j == 0) begin
                if (src.m[NORM_TOP+2]) begin
                    sh = 3;
                end else if (src.m[NORM_TOP+1]) begin
                    sh = 2;
                end else if (src.m[NORM_TOP]) begin
                    sh = 1;
                end else begin
                    sh = 0;
                end
                norm_next[j].ax = src.ax >> sh;
                norm_next[j].ay = src.ay >> sh;
                norm_next[j].m  = src.m >> sh;
            end else begin
                sh = 16 >> (j - 1);
                if (src.m < (MAG_W'(1) << (NORM_TOP - sh))) begin
                    norm_next[j].ax = src.ax << sh;
                    norm_next[j].ay = src.ay << sh;
                    norm_next[j].m  = src.m << sh;
                end
            end
        end
    end

    always_comb begin
        norm_t src;
        logic  ypos;
        src  = norm_reg[NORM_STAGES];
        ypos = !(src.yneg && (src.ay != '0));
        pre_next.zero = src.zero;
        if (src.xneg && (src.ax != '0)) begin
            pre_next.x = $signed({1'b0, src.ay});
            pre_next.y = ypos ? $signed({1'b0, src.ax}) : -$signed({1'b0, src.ax});
            pre_next.z = ypos ? DEG90 : -DEG90;
        end else begin
            pre_next.x = $signed({1'b0, src.ax});
            pre_next.y = src.yneg ? -$signed({1'b0, src.ay}) : $signed({1'b0, src.ay});
            pre_next.z = '0;
        end
    end

    always_comb begin
        rot_t                 src;
        logic signed [CW-1:0] dx, dy;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            src = (i == 0) ? pre_reg : rot_reg[(i == 0) ? 0 : i - 1];
            dx  = src.y >>> i;
            dy  = src.x >>> i;
            rot_next[i].zero = src.zero;
            if (src.y > 0) begin
                rot_next[i].x = src.x + dx;
                rot_next[i].y = src.y - dy;
                rot_next[i].z = src.z + atan_deg(i);
            end else begin
                rot_next[i].x = src.x - dx;
                rot_next[i].y = src.y + dy;
                rot_next[i].z = src.z - atan_deg(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[CORDIC_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n0_reg  <= n0_next;
            for (int j = 0; j <= NORM_STAGES; j++) begin
                norm_reg[j] <= norm_next[j];
            end
            pre_reg <= pre_next;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                rot_reg[i] <= rot_next[i];
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_LAT-1];
    assign angle_out = rot_reg[CORDIC_STEPS-1].zero ? '0 : rot_reg[CORDIC_STEPS-1].z;

endmodule

// ===== rtl/core/two_link_planar_ik_core.sv =====
// Top level of the two-link planar inverse kinematics core.
// Instantiates tlik_front, two tlik_isqrt and three tlik_cordic pipelines; uses tlik_pkg.
// The core accepts one target per clock cycle and returns one joint-angle result per target,
// in order, after 5 front-end stages, 32 square-root stages, 24 CORDIC stages and 2 output
// stages. The whole pipeline advances together; it holds only while a result sits in the
// output register and is not taken, and it keeps moving while the output register is empty.
// The link lengths are written through the configuration channel, which is always ready;
// write them only while no target is in flight. There is no clearing pass after reset.
`timescale 1ns / 1ps

module two_link_planar_ik_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // target_x [15:0], target_y [31:16], target_z [47:32]
    input  logic [tlik_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // shoulder_angle [15:0], elbow_angle [29:16], vertical_position [45:30], zero [47:46]
    output logic [tlik_pkg::M_DATA_W-1:0]      m_tdata,
    // unreachable [0]
    output logic [0:0]                         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tlik_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlik_pkg::LEN_W-1:0]         cfg_data
);
    import tlik_pkg::*;

    logic [LEN_W-1:0] l1_reg, l2_reg;
    cfg_index_t       cfg_idx;
    logic             en;

    logic             front_valid;
    front_t           front_data;
    logic             isq_e_valid, isq_s_valid;
    logic [ROOT_W-1:0] root_e, root_s;
    mid_t             mid_reg [ISQ_STEPS];
    mid_t             mid_out;

    logic                    cor_a_valid, cor_e_valid, cor_s_valid;
    logic signed [ANG_W-1:0] ang_a, ang_e, ang_s;
    tail_t                   tail_reg [CORDIC_LAT];
    tail_t                   tail_out;

    logic                    fin_valid_reg;
    tail_t                   fin_tail_reg;
    logic signed [ANG_W-1:0] sh_sum, sh_rnd_next, el_rnd_next, sh_rnd_reg, el_rnd_reg;
    logic signed [ANG_W-1:0] ang_s_g, ang_e_g, sh_sat, el_sat;

    logic                    m_tvalid_reg;
    logic [M_DATA_W-1:0]     m_tdata_reg;
    logic                    m_tuser_reg;

    assign cfg_idx   = cfg_index_t'(cfg_index);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_reg <= LINK_RESET;
            l2_reg <= LINK_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_idx)
                CFG_FIRST_LINK:  l1_reg <= cfg_data;
                CFG_SECOND_LINK: l2_reg <= cfg_data;
            endcase
        end
    end

    assign en       = ~m_tvalid_reg | m_tready;
    assign s_tready = en;

    tlik_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .x_in      ($signed(s_tdata[COORD_W-1:0])),
        .y_in      ($signed(s_tdata[2*COORD_W-1:COORD_W])),
        .z_in      ($signed(s_tdata[3*COORD_W-1:2*COORD_W])),
        .l1_in     (l1_reg),
        .l2_in     (l2_reg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    tlik_isqrt u_isqrt_e (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .rad_in    (front_data.rad_e),
        .out_valid (isq_e_valid),
        .root_out  (root_e)
    );

    tlik_isqrt u_isqrt_s (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .rad_in    (front_data.rad_s),
        .out_valid (isq_s_valid),
        .root_out  (root_s)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg[0] <= front_data.mid;
            for (int k = 1; k < ISQ_STEPS; k++) begin
                mid_reg[k] <= mid_reg[k-1];
            end
        end
    end

    assign mid_out = mid_reg[ISQ_STEPS-1];

    tlik_cordic u_cordic_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (isq_e_valid),
        .y_in      ($signed({{(CW-COORD_W){mid_out.y[COORD_W-1]}}, mid_out.y})),
        .x_in      ($signed({{(CW-COORD_W){mid_out.x[COORD_W-1]}}, mid_out.x})),
        .out_valid (cor_a_valid),
        .angle_out (ang_a)
    );

    tlik_cordic u_cordic_e (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (isq_e_valid),
        .y_in      ($signed({{(CW-ROOT_W){1'b0}}, root_e})),
        .x_in      ($signed({{(CW-NUM_W){mid_out.num_e[NUM_W-1]}}, mid_out.num_e})),
        .out_valid (cor_e_valid),
        .angle_out (ang_e)
    );

    tlik_cordic u_cordic_s (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (isq_e_valid),
        .y_in      ($signed({{(CW-ROOT_W){1'b0}}, root_s})),
        .x_in      ($signed({{(CW-NUM_W){mid_out.num_s[NUM_W-1]}}, mid_out.num_s})),
        .out_valid (cor_s_valid),
        .angle_out (ang_s)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            tail_reg[0] <= mid_out.tail;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                tail_reg[k] <= tail_reg[k-1];
            end
        end
    end

    assign tail_out = tail_reg[CORDIC_LAT-1];

    always_comb begin
        ang_s_g     = tail_out.fz_s ? '0 : ang_s;
        ang_e_g     = tail_out.fz_e ? '0 : ang_e;
        sh_sum      = ang_a + ang_s_g;
        sh_rnd_next = (sh_sum + ROUND_HALF) >>> RND_SHIFT;
        el_rnd_next = (ang_e_g + ROUND_HALF) >>> RND_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= cor_a_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sh_rnd_reg   <= sh_rnd_next;
            el_rnd_reg   <= el_rnd_next;
            fin_tail_reg <= tail_out;
        end
    end

    always_comb begin
        if (fin_tail_reg.d2zero) begin
            sh_sat = '0;
        end else if (sh_rnd_reg < SH_MIN) begin
            sh_sat = SH_MIN;
        end else if (sh_rnd_reg > SH_MAX) begin
            sh_sat = SH_MAX;
        end else begin
            sh_sat = sh_rnd_reg;
        end
        if (el_rnd_reg < 0) begin
            el_sat = '0;
        end else if (el_rnd_reg > EL_MAX) begin
            el_sat = EL_MAX;
        end else begin
            el_sat = el_rnd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {{(M_DATA_W - SH_W - EL_W - COORD_W){1'b0}}, fin_tail_reg.z,
                            el_sat[EL_W-1:0], sh_sat[SH_W-1:0]};
            m_tuser_reg <= fin_tail_reg.bad;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_isqrt_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        isq_e_valid == isq_s_valid)
        else $error("square root pipelines out of step");

    a_cordic_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (cor_a_valid == cor_e_valid) && (cor_e_valid == cor_s_valid))
        else $error("CORDIC pipelines out of step");

    a_origin_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && fin_valid_reg && fin_tail_reg.d2zero)
        |=> (m_tvalid && m_tuser[0] && (m_tdata[SH_W-1:0] == '0)))
        else $error("target at origin not flagged with zero shoulder angle");

endmodule
